// ----- design/mtt_pkg.sv -----
// shared types and constants for the move-toward-target block
`timescale 1ns / 1ps
package mtt_pkg;

  localparam int CoordW  = 32;
  localparam int FracB   = 16;
  localparam int DiffW   = CoordW + 1;
  localparam int DistW   = 34;
  localparam int RadW    = 2 * DistW;
  localparam int SqRemW  = DistW + 2;
  localparam int Step0W  = 64 - FracB;
  localparam int ProdW   = DiffW + DistW;
  localparam int QuotW   = DiffW;
  localparam int SqrtN   = DistW;
  localparam int DivN    = QuotW;

  localparam int IdxSum     = 2;
  localparam int IdxSqrtOut = IdxSum + SqrtN;
  localparam int IdxStepOut = IdxSqrtOut + 5;
  localparam int IdxMult    = IdxStepOut + 1;
  localparam int IdxLast    = IdxMult + DivN;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_SPEED  = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_DIST    = 2'd1,
    MODE_DIST_SQ = 2'd2
  } move_mode_e;

  typedef struct packed {
    logic [2:0][CoordW-1:0] cur;
    logic [2:0][CoordW-1:0] goal;
    logic [2:0][DiffW-1:0]  absd;
    logic [2:0]             negd;
    logic [31:0]            tstep;
    logic                   snap;
  } mtt_side_t;

endpackage

// ----- design/mtt_sqrt_cell.sv -----
// one digit of the square root chain
`timescale 1ns / 1ps
module mtt_sqrt_cell
  import mtt_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RadW-1:0]   rad_i,
  input  logic [SqRemW-1:0] rem_i,
  input  logic [DistW-1:0]  root_i,
  output logic [RadW-1:0]   rad_o,
  output logic [SqRemW-1:0] rem_o,
  output logic [DistW-1:0]  root_o
);

  logic [SqRemW+1:0] part;
  logic [SqRemW+1:0] trial;
  logic              ge;
  logic [RadW-1:0]   rad_d, rad_q;
  logic [SqRemW-1:0] rem_d, rem_q;
  logic [DistW-1:0]  root_d, root_q;

  always_comb begin
    part   = {rem_i, rad_i[RadW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = (part >= trial);
    rem_d  = ge ? SqRemW'(part - trial) : SqRemW'(part);
    root_d = {root_i[DistW-2:0], ge};
    rad_d  = {rad_i[RadW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ----- design/mtt_div_cell.sv -----
// one quotient bit of the offset divider chain
`timescale 1ns / 1ps
module mtt_div_cell
  import mtt_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DistW-1:0] rem_i,
  input  logic [QuotW-1:0] nb_i,
  input  logic [QuotW-1:0] q_i,
  input  logic [DistW-1:0] dist_i,
  output logic [DistW-1:0] rem_o,
  output logic [QuotW-1:0] nb_o,
  output logic [QuotW-1:0] q_o,
  output logic [DistW-1:0] dist_o
);

  logic [DistW:0]   part;
  logic             ge;
  logic [DistW-1:0] rem_q, dist_q;
  logic [QuotW-1:0] nb_q, q_q;

  always_comb begin
    part = {rem_i, nb_i[QuotW-1]};
    ge   = (part >= {1'b0, dist_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? DistW'(part - {1'b0, dist_i}) : DistW'(part);
      q_q    <= {q_i[QuotW-2:0], ge};
      nb_q   <= {nb_i[QuotW-2:0], 1'b0};
      dist_q <= dist_i;
    end
  end

  assign rem_o  = rem_q;
  assign nb_o   = nb_q;
  assign q_o    = q_q;
  assign dist_o = dist_q;

endmodule

// ----- design/mtt_step_unit.sv -----
// step length under the selected law and the snap decision
`timescale 1ns / 1ps
module mtt_step_unit
  import mtt_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [1:0]       mode_i,
  input  logic [31:0]      speed_i,
  input  logic [30:0]      radius_i,
  input  logic [DistW-1:0] dist_i,
  input  logic [31:0]      tstep_i,
  output logic [DistW-1:0] step_o,
  output logic             snap_o,
  output logic [DistW-1:0] dist_o
);

  logic [63:0]        p0_q;
  logic [DistW-1:0]   dist1_q, dist2_q, dist3_q, dist4_q, dist5_q;
  logic [Step0W-1:0]  step0_2_q, step0_3_q, step0_4_q;
  logic [65:0]        pa_q;
  logic [49:0]        pb_q;
  logic [81:0]        t1;
  logic [DistW-1:0]   s1_3_q, s1_4_q;
  logic               ovf1_3_q, ovf1_4_q;
  logic [67:0]        p2_q;
  logic [DistW-1:0]   st;
  logic               ov;
  logic [DistW-1:0]   step_q;
  logic               snap_q;

  assign t1 = {pb_q, 32'd0} + 82'(pa_q);

  always_comb begin
    case (mode_i)
      MODE_DIST: begin
        st = s1_4_q;
        ov = ovf1_4_q;
      end
      MODE_DIST_SQ: begin
        st = p2_q[FracB +: DistW];
        ov = ovf1_4_q | (|p2_q[67:FracB+DistW]);
      end
      default: begin
        st = step0_4_q[DistW-1:0];
        ov = |step0_4_q[Step0W-1:DistW];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q      <= 64'(speed_i) * 64'(tstep_i);
      dist1_q   <= dist_i;
      step0_2_q <= p0_q[63:FracB];
      pa_q      <= 66'(p0_q[FracB+31:FracB]) * 66'(dist1_q);
      pb_q      <= 50'(p0_q[63:FracB+32]) * 50'(dist1_q);
      dist2_q   <= dist1_q;
      s1_3_q    <= t1[FracB +: DistW];
      ovf1_3_q  <= |t1[81:FracB+DistW];
      step0_3_q <= step0_2_q;
      dist3_q   <= dist2_q;
      p2_q      <= 68'(s1_3_q) * 68'(dist3_q);
      s1_4_q    <= s1_3_q;
      ovf1_4_q  <= ovf1_3_q;
      step0_4_q <= step0_3_q;
      dist4_q   <= dist3_q;
      step_q    <= st;
      snap_q    <= (dist4_q == '0) || (dist4_q < DistW'(radius_i)) || ov || (st > dist4_q);
      dist5_q   <= dist4_q;
    end
  end

  assign step_o = step_q;
  assign snap_o = snap_q;
  assign dist_o = dist5_q;

endmodule

// ----- design/move_toward_target_3d_core.sv -----
// top level: moves a 3d point toward a target by one step per beat
//
//  channel | dir | content
//  s_*     | in  | tdata: cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, time_step
//  m_*     | out | tdata: new_x, new_y, new_z; tuser: reached
//  cfg_*   | in  | write: 0 move_mode, 1 move_speed, 2 snap_radius
//
// one beat per cycle in, one per cycle out while the pipe is not halted; the
// result passes the 34 cells of the square root chain and the 33 cells of the
// divider chain
// reset clears valid bits and loads the register defaults
// a result waiting at the output goes to a skid stage; the pipe halts only
// when that stage is full
`timescale 1ns / 1ps
module move_toward_target_3d_core
  import mtt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [223:0] s_tdata_i,   // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, time_step
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [95:0]  m_tdata_o,   // new_x, new_y, new_z
  output logic         m_tuser_o,   // reached
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  logic [1:0]  mode_q;
  logic [31:0] speed_q;
  logic [30:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LINEAR;
      speed_q  <= 32'h0001_0000;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_SPEED:  speed_q  <= cfg_data_i;
        CFG_RADIUS: radius_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  logic out_v_q;

  assign en         = !skid_v_q;
  assign s_tready_o = en;

  // input side
  mtt_side_t side_in;
  always_comb begin
    logic [DiffW-1:0] d;
    side_in = '0;
    for (int a = 0; a < 3; a++) begin
      side_in.cur[a]  = s_tdata_i[32*a +: 32];
      side_in.goal[a] = s_tdata_i[96+32*a +: 32];
      d = {side_in.goal[a][CoordW-1], side_in.goal[a]}
        - {side_in.cur[a][CoordW-1], side_in.cur[a]};
      side_in.negd[a] = d[DiffW-1];
      side_in.absd[a] = d[DiffW-1] ? DiffW'(-d) : d;
    end
    side_in.tstep = s_tdata_i[223:192];
  end

  mtt_side_t        side_q [IdxLast+1];
  logic [IdxLast:0] v_q;
  logic             snap_s;
  mtt_side_t        mult_in;

  always_comb begin
    mult_in      = side_q[IdxMult-1];
    mult_in.snap = snap_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[IdxLast-1:0], s_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i <= IdxLast; i++) begin
        side_q[i] <= (i == IdxMult) ? mult_in : side_q[i-1];
      end
    end
  end

  // squares and their sum
  logic [2*DiffW-1:0] sq_q [3];
  logic [RadW-1:0]    sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= (2*DiffW)'(side_q[0].absd[a]) * (2*DiffW)'(side_q[0].absd[a]);
      end
      sum_q <= RadW'(sq_q[0]) + RadW'(sq_q[1]) + RadW'(sq_q[2]);
    end
  end

  // square root chain
  logic [RadW-1:0]   rad_w  [SqrtN+1];
  logic [SqRemW-1:0] srem_w [SqrtN+1];
  logic [DistW-1:0]  root_w [SqrtN+1];

  assign rad_w[0]  = sum_q;
  assign srem_w[0] = '0;
  assign root_w[0] = '0;

  for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
    mtt_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad_w[k]),
      .rem_i  (srem_w[k]),
      .root_i (root_w[k]),
      .rad_o  (rad_w[k+1]),
      .rem_o  (srem_w[k+1]),
      .root_o (root_w[k+1])
    );
  end

  // step length and snap decision
  logic [DistW-1:0] step_s;
  logic [DistW-1:0] dist_s;

  mtt_step_unit u_step (
    .clk_i    (clk_i),
    .en_i     (en),
    .mode_i   (mode_q),
    .speed_i  (speed_q),
    .radius_i (radius_q),
    .dist_i   (root_w[SqrtN]),
    .tstep_i  (side_q[IdxSqrtOut].tstep),
    .step_o   (step_s),
    .snap_o   (snap_s),
    .dist_o   (dist_s)
  );

  // offset numerators
  logic [ProdW-1:0] prod_q [3];
  logic [DistW-1:0] dist_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= ProdW'(side_q[IdxStepOut].absd[a]) * ProdW'(step_s);
      end
      dist_m_q <= dist_s;
    end
  end

  // divider chains, one lane per axis
  logic [DistW-1:0] drem_w  [3][DivN+1];
  logic [QuotW-1:0] dnb_w   [3][DivN+1];
  logic [QuotW-1:0] dq_w    [3][DivN+1];
  logic [DistW-1:0] ddist_w [3][DivN+1];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    assign drem_w[a][0]  = prod_q[a][ProdW-1:QuotW];
    assign dnb_w[a][0]   = prod_q[a][QuotW-1:0];
    assign dq_w[a][0]    = '0;
    assign ddist_w[a][0] = dist_m_q;
    for (genvar j = 0; j < DivN; j++) begin : g_div
      mtt_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (drem_w[a][j]),
        .nb_i   (dnb_w[a][j]),
        .q_i    (dq_w[a][j]),
        .dist_i (ddist_w[a][j]),
        .rem_o  (drem_w[a][j+1]),
        .nb_o   (dnb_w[a][j+1]),
        .q_o    (dq_w[a][j+1]),
        .dist_o (ddist_w[a][j+1])
      );
    end
  end

  // final position: the goal on snap, else the sum with saturation
  logic [95:0] res_data;
  logic        res_reached;

  always_comb begin
    logic signed [CoordW+1:0] sum;
    logic        [CoordW+1:0] cur_x;
    logic        [CoordW+1:0] off;
    mtt_side_t   sd;
    sd          = side_q[IdxLast];
    res_reached = sd.snap;
    for (int a = 0; a < 3; a++) begin
      cur_x = {{2{sd.cur[a][CoordW-1]}}, sd.cur[a]};
      off   = {1'b0, dq_w[a][DivN]};
      sum   = sd.negd[a] ? signed'(cur_x - off) : signed'(cur_x + off);
      if (sd.snap) begin
        res_data[32*a +: 32] = sd.goal[a];
      end else if (sum > signed'({3'b000, {(CoordW-1){1'b1}}})) begin
        res_data[32*a +: 32] = {1'b0, {(CoordW-1){1'b1}}};
      end else if (sum < signed'({3'b111, {(CoordW-1){1'b0}}})) begin
        res_data[32*a +: 32] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        res_data[32*a +: 32] = sum[CoordW-1:0];
      end
    end
  end

  // output register and skid stage
  logic        res_v;
  logic [95:0] out_data_q, skid_data_q;
  logic        out_user_q, skid_user_q;

  assign res_v = v_q[IdxLast] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_tready_i) begin
      out_v_q  <= skid_v_q || res_v;
      skid_v_q <= 1'b0;
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_tready_i) begin
      out_data_q <= skid_v_q ? skid_data_q : res_data;
      out_user_q <= skid_v_q ? skid_user_q : res_reached;
    end else if (res_v) begin
      skid_data_q <= res_data;
      skid_user_q <= res_reached;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule

// ----- tb/move_toward_target_3d_core_tb.sv -----
// testbench for the move-toward-target core: random and directed points, scoreboard check
`timescale 1ns / 1ps
module move_toward_target_3d_core_tb
  import mtt_pkg::*;
;

  localparam int WdogLimit = 20000;

  typedef struct {
    logic signed [31:0] cur [3];
    logic signed [31:0] goal [3];
    logic [31:0]        tstep;
  } point_t;

  typedef struct {
    logic [31:0] pos [3];
    logic        reached;
  } step_res_t;

  class move_scoreboard;
    logic [1:0]  mode;
    logic [31:0] speed;
    logic [30:0] radius;
    step_res_t   pending[$];
    int          mismatches;

    function new();
      mode = MODE_LINEAR;
      speed = 32'h0001_0000;
      radius = '0;
      mismatches = 0;
    endfunction

    function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      if (p[127:64+FracB] != 0) return '1;
      return p[64+FracB-1:FracB];
    endfunction

    function void note_point(point_t pt);
      logic signed [63:0] d [3];
      logic [63:0]        ad [3];
      logic [127:0]       sum, prod, q;
      logic [63:0]        dlen, stp, r, c, mag;
      logic signed [63:0] v;
      step_res_t          res;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 64'(pt.goal[i]) - 64'(pt.cur[i]);
        ad[i] = d[i] < 0 ? -d[i] : d[i];
        sum += 128'(ad[i]) * 128'(ad[i]);
      end
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= sum) r = c;
      end
      dlen = r;
      stp = fx_mul(64'(speed), 64'(pt.tstep));
      if (mode == MODE_DIST || mode == MODE_DIST_SQ) stp = fx_mul(stp, dlen);
      if (mode == MODE_DIST_SQ) stp = fx_mul(stp, dlen);
      if (dlen == 0 || dlen < 64'(radius) || stp > dlen) begin
        for (int i = 0; i < 3; i++) res.pos[i] = pt.goal[i];
        res.reached = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          prod = 128'(ad[i]) * 128'(stp);
          q = prod / 128'(dlen);
          mag = (q[127:64] != 0) ? '1 : q[63:0];
          mag[63:62] = 2'b00;
          v = d[i] < 0 ? 64'(pt.cur[i]) - $signed(mag) : 64'(pt.cur[i]) + $signed(mag);
          if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
          if (v < -64'sh8000_0000) v = -64'sh8000_0000;
          res.pos[i] = v[31:0];
        end
        res.reached = 1'b0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [95:0] data, logic reached);
      step_res_t exp_r;
      logic      bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h reached %b", data, reached);
        return;
      end
      exp_r = pending.pop_front();
      bad = reached !== exp_r.reached;
      for (int i = 0; i < 3; i++) bad |= data[32*i +: 32] !== exp_r.pos[i];
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h r%b, got %h %h %h r%b",
                   exp_r.pos[0], exp_r.pos[1], exp_r.pos[2], exp_r.reached,
                   data[31:0], data[63:32], data[95:64], reached);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [223:0] s_tdata_i = '0;  // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, time_step
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [95:0]  m_tdata_o;       // new_x, new_y, new_z
  logic         m_tuser_o;       // reached
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  move_scoreboard sb = new();
  point_t         fed[$];
  bit             sending = 1'b1;
  bit             hold_sink = 1'b0;
  int             idle_cycles = 0;

  move_toward_target_3d_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scoreboard updates on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) sb.note_point(fed.pop_front());
      if (m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o, m_tuser_o);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WdogLimit) begin
        $display("move_toward_target_3d_core test failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, none for stretches, plus a long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_tready_i <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid_o) @(posedge clk_i);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:   sb.mode = val[1:0];
      CFG_SPEED:  sb.speed = val;
      CFG_RADIUS: sb.radius = val[30:0];
      default: ;
    endcase
  endtask

  task automatic send_point(point_t pt, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {pt.tstep, pt.goal[2], pt.goal[1], pt.goal[0],
                  pt.cur[2], pt.cur[1], pt.cur[0]};
    fed.push_back(pt);
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0 || fed.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(signed'($urandom_range(0, 16'hFFFF)) - 32'sh8000);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    int     kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      pt.cur[i] = rand_coord(kind);
      pt.goal[i] = ($urandom_range(0, 9) == 0) ? pt.cur[i] : rand_coord($urandom_range(0, 3));
    end
    case ($urandom_range(0, 3))
      0: pt.tstep = $urandom();
      1: pt.tstep = $urandom_range(0, 32'h0002_0000);
      2: pt.tstep = $urandom_range(0, 32'h0000_0400);
      default: pt.tstep = $urandom_range(0, 32'h0020_0000);
    endcase
    return pt;
  endfunction

  function automatic point_t mk(logic [31:0] c, logic [31:0] g, logic [31:0] t);
    point_t pt;
    for (int i = 0; i < 3; i++) begin
      pt.cur[i] = c;
      pt.goal[i] = g;
    end
    pt.tstep = t;
    return pt;
  endfunction

  logic [31:0] speeds [5] = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                              32'h0000_0100, 32'h0000_4000};
  logic [31:0] radii [5] = '{32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000,
                             32'h0100_0000};

  initial begin
    point_t pt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero distance, overshoot, exact landing, unused mode
    send_point(mk(32'h0, 32'h0, 32'h0001_0000), 0);
    send_point(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001), 0);
    send_point(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF), 0);
    send_point(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0), 0);
    pt = mk(32'h0, 32'h0, 32'h0001_0000);
    pt.goal[0] = 32'h0001_0000;
    send_point(pt, 0);
    pt.tstep = 32'h0000_8000;
    send_point(pt, 0);
    send_point(mk(32'h1234_5678, 32'hEDCB_A987, 32'h0003_0000), 0);
    drain();
    write_cfg(CFG_MODE, 32'd3);
    send_point(mk(32'h0, 32'h0010_0000, 32'h0000_8000), 0);
    send_point(mk(32'hFFFF_0000, 32'h8000_0000, 32'h0001_0000), 0);
    drain();
    for (int m = 0; m < 3; m++) begin
      write_cfg(CFG_MODE, 32'(m));
      write_cfg(CFG_SPEED, 32'h0000_0100);
      send_point(mk(32'h0, 32'h0010_0000, 32'h0000_8000), 0);
      send_point(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001), 0);
      send_point(mk(32'h0, 32'h0000_0003, 32'hFFFF_FFFF), 0);
      drain();
    end

    // random phases over register settings
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_MODE, 32'(ph % 4));
      write_cfg(CFG_SPEED, (ph < 5) ? speeds[ph] : $urandom());
      write_cfg(CFG_RADIUS, (ph < 5) ? radii[ph] : 32'($urandom_range(0, 32'h00FF_FFFF)));
      if (ph == 3) hold_sink = 1'b1;
      for (int n = 0; n < 110; n++) send_point(rand_point(), ($urandom_range(0, 4) == 0));
      drain();
    end

    if (sb.mismatches == 0) $display("move_toward_target_3d_core test passed");
    else $display("move_toward_target_3d_core test failed");
    $finish;
  end

endmodule
